// ===== sv/assert_macros.svh =====
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle property, checked outside reset
`define ASSERT_NOW(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent implies consequent on the following clock
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pcxrle_pkg.sv =====
// types and constants of the pcx run-length decoder
package pcxrle_pkg;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 6;
    localparam int LB_W     = 18;
    localparam int LC_W     = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] RUN_MARK = 2'b11;

    localparam logic [LB_W-1:0] LINE_BYTES_RST = 18'd2;
    localparam logic [LC_W-1:0] LINE_COUNT_RST = 17'd1;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic starts_run;
        logic out_free;
        logic run_last;
    } sts_t;

endpackage

// ===== sv/pcxrle_ctrl.sv =====
// controller state machine of the pcx run-length decoder
`include "assert_macros.svh"

module pcxrle_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pcxrle_pkg::sts_t  sts,
    output pcxrle_pkg::cmd_t  cmd
);
    import pcxrle_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready   = (state_reg == ST_IDLE);
    assign cmd.accept = in_ready && in_valid;
    assign cmd.emit   = (state_reg == ST_RUN) && sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && sts.starts_run)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.emit && sts.run_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_NEXT(a_run_ends_idle, clk, rst_n, cmd.emit && sts.run_last, in_ready, "run did not close after its last beat")
    `ASSERT_NEXT(a_accept_no_run, clk, rst_n, cmd.accept && !sts.starts_run, in_ready, "byte without output left the controller busy")

endmodule

// ===== sv/pcxrle_dp.sv =====
// datapath of the pcx run-length decoder: run state, line counters, output register
`include "assert_macros.svh"

module pcxrle_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pcxrle_pkg::cmd_t                      cmd,
    output pcxrle_pkg::sts_t                      sts,
    input  logic [pcxrle_pkg::BYTE_W-1:0]         in_byte,
    input  logic                                  cfg_we,
    input  logic [pcxrle_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [pcxrle_pkg::LB_W-1:0]           cfg_wdata,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [pcxrle_pkg::BYTE_W-1:0]         out_byte,
    output logic                                  out_line_end,
    output logic                                  out_image_end,
    output logic                                  out_run_last
);
    import pcxrle_pkg::*;

    logic [LB_W-1:0]    line_bytes_reg;
    logic [LC_W-1:0]    line_count_reg;
    logic               awaiting_reg;
    logic [COUNT_W-1:0] pending_reg;
    logic [COUNT_W-1:0] reps_reg;
    logic [BYTE_W-1:0]  value_reg;
    logic [LB_W-1:0]    bytes_left_reg;
    logic [LC_W-1:0]    lines_done_reg;
    logic               image_done_reg;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_line_end_reg;
    logic               out_image_end_reg;
    logic               out_run_last_reg;

    logic               is_mark;
    logic               line_ends;
    logic [LC_W-1:0]    lines_inc;
    logic               image_ends;

    assign is_mark    = (in_byte[BYTE_W-1 -: 2] == RUN_MARK);
    assign line_ends  = (bytes_left_reg <= {{(LB_W-1){1'b0}}, 1'b1});
    assign lines_inc  = lines_done_reg + {{(LC_W-1){1'b0}}, 1'b1};
    assign image_ends = line_ends &&
                        ((lines_inc >= line_count_reg) || (line_count_reg == '0));

    assign sts.starts_run = !image_done_reg &&
                            (awaiting_reg ? (pending_reg != '0) : !is_mark);
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.run_last   = (reps_reg == {{(COUNT_W-1){1'b0}}, 1'b1}) || line_ends;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_bytes_reg <= LINE_BYTES_RST;
            line_count_reg <= LINE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_LINE_BYTES: line_bytes_reg <= cfg_wdata;
                REG_LINE_COUNT: line_count_reg <= cfg_wdata[LC_W-1:0];
                default:        line_count_reg <= line_count_reg;
            endcase
        end
    end

    // run decode and line tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg   <= 1'b0;
            pending_reg    <= '0;
            reps_reg       <= '0;
            bytes_left_reg <= LINE_BYTES_RST;
            lines_done_reg <= '0;
            image_done_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (!image_done_reg)
            begin
                if (awaiting_reg)
                begin
                    awaiting_reg <= 1'b0;
                    pending_reg  <= '0;
                    reps_reg     <= pending_reg;
                end
                else if (is_mark)
                begin
                    awaiting_reg <= 1'b1;
                    pending_reg  <= in_byte[COUNT_W-1:0];
                end
                else
                begin
                    reps_reg <= {{(COUNT_W-1){1'b0}}, 1'b1};
                end
            end
        end
        else if (cmd.emit)
        begin
            reps_reg <= sts.run_last ? '0 : reps_reg - {{(COUNT_W-1){1'b0}}, 1'b1};
            if (line_ends)
            begin
                bytes_left_reg <= line_bytes_reg;
                lines_done_reg <= lines_inc;
                if (image_ends)
                begin
                    image_done_reg <= 1'b1;
                end
            end
            else
            begin
                bytes_left_reg <= bytes_left_reg - {{(LB_W-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            value_reg <= in_byte;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg      <= value_reg;
            out_line_end_reg  <= line_ends;
            out_image_end_reg <= image_ends;
            out_run_last_reg  <= sts.run_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_line_end  = out_line_end_reg;
    assign out_image_end = out_image_end_reg;
    assign out_run_last  = out_run_last_reg;

    `ASSERT_NOW(a_emit_has_reps, clk, rst_n, !cmd.emit || (reps_reg != '0), "beat emitted with no repeats left")
    `ASSERT_NOW(a_no_emit_after_image, clk, rst_n, !cmd.emit || !image_done_reg, "beat emitted after the image ended")

endmodule

// ===== sv/pcx_rle_scanline_decoder.sv =====
// top level of the pcx run-length scanline decoder
`include "assert_macros.svh"

// usage
// - s_axis carries the compressed pcx pixel stream, one byte per beat
// - m_axis carries decoded scanline bytes; tlast marks the last byte of a
//   scanline, tuser[0] the last byte of the image, tuser[1] the last beat
//   caused by one input byte
// - cfg_we/cfg_addr/cfg_wdata write line_bytes (index 0) and line_count
//   (index 1); write them only while the decoder is idle
// - a literal is accepted while idle, then emitted once in the run state,
//   which loads its beat into the output register
// - the value byte of a run of n is accepted while idle, then the run state
//   keeps s_axis_tready low and puts one beat per cycle into the output
//   register while it is free; a run cut at the line end stops after its last beat
// - a count byte, a zero-count run and bytes after the image end are
//   absorbed with no output and the decoder stays idle
// - runs are cut at the end of the scanline and the excess is dropped
// - reset clears the run state and line counters and loads line_bytes = 2,
//   line_count = 1; no clearing pass is needed
// - when m_axis_tready is low while a beat is held, the beat holds and the
//   run pauses until it is taken; no data is lost
module pcx_rle_scanline_decoder
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // config write port
    input  logic                                  cfg_we,
    input  logic [pcxrle_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [pcxrle_pkg::LB_W-1:0]           cfg_wdata,
    // compressed input
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,   // [7:0] in_byte
    // decoded output
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [7:0]                            m_axis_tdata,   // [7:0] out_byte
    output logic                                  m_axis_tlast,   // line_end
    output logic [1:0]                            m_axis_tuser    // [0] image_end, [1] run_last
);
    import pcxrle_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: idle accepts a beat, run emits the repeats
    pcxrle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // run decode, line/image counters and output register
    pcxrle_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_byte       (s_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_byte      (m_axis_tdata),
        .out_line_end  (m_axis_tlast),
        .out_image_end (m_axis_tuser[0]),
        .out_run_last  (m_axis_tuser[1])
    );

    // the image can only end on a scanline end, and a line end closes the run
    `ASSERT_NOW(a_image_end_on_line, clk, rst_n, !m_axis_tvalid || !m_axis_tuser[0] || m_axis_tlast, "image end without line end")
    `ASSERT_NOW(a_line_end_run_last, clk, rst_n, !m_axis_tvalid || !m_axis_tlast || m_axis_tuser[1], "line end not marked as run last")

endmodule

// ===== bench/tb_pcx_rle_scanline_decoder.sv =====
// self-checking testbench for the pcx run-length scanline decoder
`timescale 1ns / 1ps

module tb_pcx_rle_scanline_decoder;

    import pcxrle_pkg::*;

    // line_count that never ends the image during the main phases
    localparam logic [LB_W-1:0] LC_NEVER_ENDS = 18'd65536;
    localparam logic [LB_W-1:0] LB_LARGEST   = 18'd262140;
    localparam int N_PHASES      = 9;
    localparam int PHASE_BYTES   = 37;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;

    // one decoded output beat as the decoder should produce it
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              line_end;
        logic              image_end;
        logic              run_last;
    } decoded_beat_t;

    // keeps its own copy of the decoder state and the geometry registers,
    // expands every accepted compressed byte into the beats it must produce
    class scanline_scoreboard;
        logic [LB_W-1:0]    line_bytes;
        logic [LC_W-1:0]    line_count;
        bit                 awaiting_value;
        logic [COUNT_W-1:0] pending_count;
        logic [LB_W-1:0]    bytes_left;
        logic [LC_W-1:0]    lines_done;
        bit                 image_done;
        decoded_beat_t      decoded_due[$];
        int                 errors;

        function new();
            line_bytes     = LINE_BYTES_RST;
            line_count     = LINE_COUNT_RST;
            awaiting_value = 1'b0;
            pending_count  = '0;
            bytes_left     = LINE_BYTES_RST;
            lines_done     = '0;
            image_done     = 1'b0;
            errors         = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LB_W-1:0] value);
            case (idx)
                REG_LINE_BYTES: line_bytes = value;
                REG_LINE_COUNT: line_count = value[LC_W-1:0];
                default: ;
            endcase
        endfunction

        // expand one compressed byte into the scanline bytes it yields
        function void take_compressed(logic [BYTE_W-1:0] b);
            int            reps;
            decoded_beat_t beat;
            if (image_done)
                return;
            if (awaiting_value)
            begin
                awaiting_value = 1'b0;
                reps           = pending_count;
                pending_count  = '0;
            end
            else if (b[7:6] == RUN_MARK)
            begin
                // count byte, the value comes with the next beat
                awaiting_value = 1'b1;
                pending_count  = b[COUNT_W-1:0];
                return;
            end
            else
                reps = 1;

            while (reps > 0)
            begin
                beat.out_byte  = b;
                beat.line_end  = 1'b0;
                beat.image_end = 1'b0;
                // a zero remaining count counts as one
                if (bytes_left <= 1)
                begin
                    beat.line_end = 1'b1;
                    lines_done    = lines_done + 1'b1;
                    bytes_left    = line_bytes;
                    if (lines_done >= line_count || line_count == '0)
                    begin
                        beat.image_end = 1'b1;
                        image_done     = 1'b1;
                    end
                end
                else
                    bytes_left = bytes_left - 1'b1;
                reps--;
                // the rest of a run is dropped at the end of a line
                beat.run_last = (reps == 0) || beat.line_end;
                decoded_due.push_back(beat);
                if (beat.run_last)
                    break;
            end
        endfunction

        function void check_beat(logic [BYTE_W-1:0] data, logic last, logic [1:0] user);
            decoded_beat_t want;
            if (decoded_due.size() == 0)
            begin
                $error("unexpected output beat: out_byte=%02h line_end=%0b user=%02b",
                       data, last, user);
                errors++;
                return;
            end
            want = decoded_due.pop_front();
            if (want.out_byte !== data)
            begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, data);
                errors++;
            end
            if (want.line_end !== last)
            begin
                $error("line_end: expected %0b, got %0b", want.line_end, last);
                errors++;
            end
            if (want.image_end !== user[0])
            begin
                $error("image_end: expected %0b, got %0b", want.image_end, user[0]);
                errors++;
            end
            if (want.run_last !== user[1])
            begin
                $error("run_last: expected %0b, got %0b", want.run_last, user[1]);
                errors++;
            end
        endfunction

        function int pending();
            return decoded_due.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [LB_W-1:0]      cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // [7:0] in_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;   // [7:0] out_byte
    logic                 m_axis_tlast;   // line_end
    logic [1:0]           m_axis_tuser;   // [0] image_end, [1] run_last

    scanline_scoreboard decoder_sb;

    // percent chance per cycle that the sender holds back or the sink stalls
    int send_idle_pct;
    int recv_stall_pct;

    pcx_rle_scanline_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the decoder hangs or drops beats
    initial
    begin
        #10_000_000;
        $display("** pcx_rle_scanline_decoder: FAILED **");
        $finish;
    end

    // sink side: random backpressure, changed only on the falling edge
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // every accepted output beat is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            decoder_sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // mode 0: sender rarely idles, sink stalls a lot; mode 1: the reverse;
    // mode 2: no idling on either side
    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct  = 8;
                recv_stall_pct = 58;
            end
            1:
            begin
                send_idle_pct  = 58;
                recv_stall_pct = 8;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // called on a falling edge; returns on the falling edge after the beat
    // was taken with tvalid still high, so the caller pushes again or drains
    task automatic push_byte(input logic [7:0] b);
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        decoder_sb.take_compressed(b);
        @(negedge clk);
    endtask

    // sender pauses until every decoded byte is back, then lets the decoder
    // settle since a count byte or an empty run leaves nothing to wait for
    task automatic drain_decoder();
        s_axis_tvalid <= 1'b0;
        while (decoder_sb.pending() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // both geometry registers, back to back, only while the decoder is idle
    task automatic set_geometry(input logic [LB_W-1:0] lb, input logic [LB_W-1:0] lc);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_LINE_BYTES;
        cfg_wdata <= lb;
        decoder_sb.write_reg(REG_LINE_BYTES, lb);
        @(negedge clk);
        cfg_addr  <= REG_LINE_COUNT;
        cfg_wdata <= lc;
        decoder_sb.write_reg(REG_LINE_COUNT, lc);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one piece of a pcx stream: mostly literals and count/value pairs,
    // some stray bytes of any value
    task automatic push_stream_piece(output int n_sent);
        int            roll;
        logic [5:0]    count;
        roll = $urandom_range(99, 0);
        if (roll < 10)
        begin
            push_byte(8'($urandom_range(255, 0)));
            n_sent = 1;
        end
        else if (roll < 55)
        begin
            // literal: top two bits never both set
            push_byte(8'($urandom_range(8'hbf, 0)));
            n_sent = 1;
        end
        else
        begin
            roll = $urandom_range(99, 0);
            if (roll < 70)
                count = 6'($urandom_range(6, 1));
            else if (roll < 90)
                count = 6'($urandom_range(63, 0));
            else
                count = '0;
            push_byte({RUN_MARK, count});
            push_byte(8'($urandom_range(255, 0)));
            n_sent = 2;
        end
    endtask

    initial
    begin
        int               sent;
        int               piece;
        int               pick;
        int               wait_cycles;
        logic [LB_W-1:0]  lb;
        logic [LB_W-1:0]  lc;

        decoder_sb    = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_LINE_BYTES;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        set_idling(0);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed stream on 5-byte lines, the image never ends here
        set_geometry(18'd5, LC_NEVER_ENDS);
        push_byte(8'h00);                       // smallest literal
        push_byte(8'hbf);                       // largest literal
        push_byte(8'hc0); push_byte(8'h12);     // empty run, value swallowed
        push_byte(8'hc1); push_byte(8'hff);     // run of one
        push_byte(8'hc3); push_byte(8'hc7);     // run of three, stays inside the line
        push_byte(8'hff); push_byte(8'h5a);     // longest run, cut at the line end
        push_byte(8'h7f);
        push_byte(8'h80);
        push_byte(8'h40);
        push_byte(8'hc2); push_byte(8'h01);     // run ends exactly on the line end
        push_byte(8'h3c);                       // next line starts fresh
        drain_decoder();

        // random phases, each with its own geometry; phase ends are left
        // mid-line but never mid-run, so the writes land there too
        for (int p = 0; p < N_PHASES; p++)
        begin
            set_idling(p * 3 / N_PHASES);
            case (p)
                0:       lb = 18'd1;                    // every byte ends a line
                1:       lb = 18'd0;                    // zero length acts as one
                4:       lb = LB_LARGEST;
                7:       lb = LB_LARGEST;
                default: lb = 18'($urandom_range(64, 2));
            endcase
            if (p % 2 == 0)
                lc = LC_NEVER_ENDS;
            else
                lc = 18'($urandom_range(65535, 60000));
            set_geometry(lb, lc);
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                push_stream_piece(piece);
                sent += piece;
            end
            drain_decoder();
        end

        // last phase: the line count is lowered so the image ends, either
        // right at the next line end or at the line end after it
        pick = $urandom_range(2, 0);
        case (pick)
            0:       lc = '0;
            1:       lc = 18'd1;
            default: lc = 18'(decoder_sb.lines_done) + 18'd2;
        endcase
        set_geometry(18'($urandom_range(24, 1)), lc);
        while (!decoder_sb.image_done)
            push_stream_piece(piece);
        // past the image end every byte is dropped
        repeat (10) push_byte(8'($urandom_range(255, 0)));

        s_axis_tvalid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < DRAIN_LIMIT && decoder_sb.pending() > 0;
             wait_cycles++)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (decoder_sb.pending() != 0)
        begin
            $error("%0d decoded bytes never arrived", decoder_sb.pending());
            decoder_sb.errors++;
        end

        if (decoder_sb.errors == 0)
            $display("** pcx_rle_scanline_decoder: PASSED **");
        else
            $display("** pcx_rle_scanline_decoder: FAILED **");
        $finish;
    end

endmodule

// ===== pcx_rle_scanline_decoder.f =====
+incdir+sv
sv/pcxrle_pkg.sv
sv/pcxrle_ctrl.sv
sv/pcxrle_dp.sv
sv/pcx_rle_scanline_decoder.sv
bench/tb_pcx_rle_scanline_decoder.sv
